### sv/cspbp_pkg.sv
// Shared widths, function codes and defaults for the code/symbol pair bit packer.
`default_nettype none

package cspbp_pkg;

   localparam int CODE_W       = 16;
   localparam int CODE_WIDTH_W = 5;
   localparam int SYMBOL_W     = 8;
   localparam int BYTE_W       = 8;
   localparam int PEND_W       = 7;
   localparam int CNT_W        = 3;
   localparam int DEFAULT_MAX_CODE_WIDTH = 16;

   typedef enum logic {
      FUNC_PAIR  = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

endpackage

`default_nettype wire

### sv/cspbp_if.sv
// Valid/ready channel interfaces for the pair input and the byte output.
`default_nettype none

interface cspbp_req_if;
   import cspbp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [CODE_W-1:0]       code;
   logic [CODE_WIDTH_W-1:0] code_width;
   logic [SYMBOL_W-1:0]     symbol;

   modport source (output valid, output func, output code, output code_width,
                   output symbol, input ready);
   modport sink   (input valid, input func, input code, input code_width,
                   input symbol, output ready);
endinterface

interface cspbp_rsp_if;
   import cspbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/code_symbol_pair_bit_packer_top.sv
// Top level of the code/symbol pair bit packer: LSB-first packing into bytes.
// Latency: an accepted item's first byte is offered on the cycle after acceptance.
// Throughput: one output byte per cycle from the byte register while the output is ready;
// a pair gives 1 to 3 bytes, a flush one byte if bits are pending, else none. The next item
// is taken while the last byte of the previous one is being taken.
// Reset (synchronous, active high) clears the pending bits and drops queued bytes.
`default_nettype none

module code_symbol_pair_bit_packer_top #(
   parameter int MAX_CODE_WIDTH = cspbp_pkg::DEFAULT_MAX_CODE_WIDTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cspbp_req_if.sink   req_chan,
   cspbp_rsp_if.source rsp_chan
);
   import cspbp_pkg::*;

   localparam int CodeLimit = (MAX_CODE_WIDTH < CODE_W) ? MAX_CODE_WIDTH : CODE_W;
   localparam int AccW      = PEND_W + CODE_W + SYMBOL_W;
   localparam int WordW     = 3 * BYTE_W;

   logic [PEND_W-1:0]       pend_bits_ff, pend_bits_in;
   logic [CNT_W-1:0]        pend_cnt_ff, pend_cnt_in;
   logic [WordW-1:0]        word_ff, word_in;
   logic [1:0]              left_ff, left_in;

   logic                    req_fire, rsp_fire;
   logic [CODE_WIDTH_W-1:0] width_eff;
   logic [CODE_W:0]         mask_wide;
   logic [CODE_W-1:0]       code_masked;
   logic [CODE_WIDTH_W-1:0] sym_shift;
   logic [AccW-1:0]         acc;
   logic [CODE_WIDTH_W-1:0] total;
   logic [1:0]              nbytes;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   // Ready while the byte register is empty or is handing over its final byte.
   assign req_chan.ready = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = (left_ff != 2'd0);
   assign rsp_chan.out_byte    = word_ff[BYTE_W-1:0];
   assign rsp_chan.last_of_run = (left_ff == 2'd1);

   always_comb begin
      width_eff = (req_chan.code_width > CODE_WIDTH_W'(CodeLimit)) ?
                  CODE_WIDTH_W'(CodeLimit) : req_chan.code_width;
      mask_wide   = ((CODE_W+1)'(1) << width_eff) - (CODE_W+1)'(1);
      code_masked = req_chan.code & mask_wide[CODE_W-1:0];
      sym_shift   = CODE_WIDTH_W'(pend_cnt_ff) + width_eff;
      acc = AccW'(pend_bits_ff)
          | (AccW'(code_masked) << pend_cnt_ff)
          | (AccW'(req_chan.symbol) << sym_shift);
      total  = CODE_WIDTH_W'(pend_cnt_ff) + width_eff + CODE_WIDTH_W'(BYTE_W);
      nbytes = total[CODE_WIDTH_W-1:3];
   end

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      word_in      = word_ff;
      left_in      = left_ff;
      if (rsp_fire) begin
         word_in = word_ff >> BYTE_W;
         left_in = left_ff - 2'd1;
      end
      if (req_fire) begin
         if (req_chan.func == FUNC_FLUSH) begin
            if (pend_cnt_ff != '0) begin
               word_in = WordW'(pend_bits_ff);
               left_in = 2'd1;
            end
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            // Bits past the count are zero, so the shifted remainder needs no mask.
            word_in      = acc[WordW-1:0];
            left_in      = nbytes;
            pend_bits_in = PEND_W'(acc >> {nbytes, 3'b000});
            pend_cnt_in  = total[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         left_ff      <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff >> pend_cnt_ff) == '0)
      else $error("pending bits set above the pending count");

   a_pair_gives_byte: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.func == FUNC_PAIR) |=> (left_ff != 2'd0))
      else $error("pair produced no output byte");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.func == FUNC_FLUSH) |=> (pend_cnt_ff == '0) && (left_ff <= 2'd1))
      else $error("flush left pending bits or extra bytes");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (left_ff == 2'd1) && !req_fire |=> (left_ff == 2'd0))
      else $error("byte register not empty after final beat");

endmodule

`default_nettype wire
